[rtl/rbst_pkg.sv]
// ----------------------------------------------------------------------------
// Ring buffer space tracker package
// Request codes and the packed result layout shared by the tracker.
// ----------------------------------------------------------------------------
package rbst_pkg;

    localparam int ACTION_W   = 2;
    localparam int REQUEST_W  = 16;
    localparam int COUNT_W    = 13;
    localparam int OFFSET_W   = 12;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 104;
    localparam int RESULT_W   = 4 * COUNT_W + 2 * COUNT_W + 2 * OFFSET_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PRODUCE = 2'd0,
        ACT_CONSUME = 2'd1,
        ACT_CLEAR   = 2'd2
    } action_t;

    // Field order from the lowest bit up: done_count first.
    typedef struct packed {
        logic [COUNT_W-1:0]  write_second_length;
        logic [COUNT_W-1:0]  write_first_length;
        logic [OFFSET_W-1:0] write_start;
        logic [COUNT_W-1:0]  read_second_length;
        logic [COUNT_W-1:0]  read_first_length;
        logic [OFFSET_W-1:0] read_start;
        logic [COUNT_W-1:0]  fill_level;
        logic [COUNT_W-1:0]  done_count;
    } result_t;

endpackage

[rtl/ring_buffer_space_tracker.sv]
// ----------------------------------------------------------------------------
// Ring buffer space tracker
// Keeps write offset, read offset and fill of a byte ring of BUFFER_BYTES
// bytes and reports the amount done plus readable and writable views.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one request per beat: an action (produce, consume,
//   clear, anything else is a no-op) and a byte count. Produce is clamped to
//   the free space, consume to the fill. A consume that empties the ring
//   returns both offsets to zero.
//   m_ channel returns one result per request with the bytes done, the fill
//   and the two-segment read and write views after the request.
//   A request accepted on s_ passes the input register, then the result
//   register, before its result shows on m_.
//   Throughput: one request per cycle while m_tready is high; the offset and
//   fill registers are updated by one pass of add, compare and wrap logic.
//   Stall: while m_tready is low the result holds; one more request can wait
//   in the input register, after that s_tready drops.
//   Reset: aresetn low clears both offsets, the fill and both valid flags.
// ----------------------------------------------------------------------------
module ring_buffer_space_tracker #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [1:0] action, [17:2] request_count, [23:18] zero
    input  logic [rbst_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [12:0] done_count, [25:13] fill_level, [37:26] read_start,
    // [50:38] read_first_length, [63:51] read_second_length,
    // [75:64] write_start, [88:76] write_first_length,
    // [101:89] write_second_length, [103:102] zero
    output logic [rbst_pkg::M_TDATA_W-1:0]    m_tdata
);
    import rbst_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam int OFF_W = $clog2(BUFFER_BYTES);
    localparam int CMP_W = (CNT_W > REQUEST_W) ? CNT_W : REQUEST_W;
    localparam logic [CNT_W-1:0] SIZE = CNT_W'(BUFFER_BYTES);

    logic                 in_valid_reg;
    logic [ACTION_W-1:0]  action_reg;
    logic [REQUEST_W-1:0] request_reg;
    logic                 out_valid_reg;
    result_t              result_reg;
    result_t              result_next;

    logic [OFF_W-1:0]     wr_off_reg, wr_off_next;
    logic [OFF_W-1:0]     rd_off_reg, rd_off_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;

    logic                 advance;
    logic [CNT_W-1:0]     free_cur;
    logic [CNT_W-1:0]     done;
    logic [CNT_W:0]       wr_sum, rd_sum;
    logic [OFF_W-1:0]     wr_adv, rd_adv;
    logic [CNT_W-1:0]     rd_chunk, wr_chunk, free_new;
    logic [CNT_W-1:0]     r_first, r_second, w_first, w_second;
    logic [31:0]          done_w, fill_w, rd_w, rf_w, rs_w, wr_w, wf_w, ws_w;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, result_reg};

    assign free_cur = SIZE - fill_reg;

    always_comb begin
        case (action_reg)
            ACT_PRODUCE: begin
                done = (CMP_W'(request_reg) < CMP_W'(free_cur)) ?
                       CNT_W'(request_reg) : free_cur;
            end
            ACT_CONSUME: begin
                done = (CMP_W'(request_reg) < CMP_W'(fill_reg)) ?
                       CNT_W'(request_reg) : fill_reg;
            end
            default: begin
                done = '0;
            end
        endcase
    end

    // wrap offset + done at the ring size
    assign wr_sum = (CNT_W + 1)'(wr_off_reg) + (CNT_W + 1)'(done);
    assign rd_sum = (CNT_W + 1)'(rd_off_reg) + (CNT_W + 1)'(done);
    assign wr_adv = (wr_sum >= (CNT_W + 1)'(SIZE)) ?
                    OFF_W'(wr_sum - (CNT_W + 1)'(SIZE)) : OFF_W'(wr_sum);
    assign rd_adv = (rd_sum >= (CNT_W + 1)'(SIZE)) ?
                    OFF_W'(rd_sum - (CNT_W + 1)'(SIZE)) : OFF_W'(rd_sum);

    always_comb begin
        wr_off_next = wr_off_reg;
        rd_off_next = rd_off_reg;
        fill_next   = fill_reg;
        case (action_reg)
            ACT_PRODUCE: begin
                wr_off_next = wr_adv;
                fill_next   = fill_reg + done;
            end
            ACT_CONSUME: begin
                fill_next = fill_reg - done;
                if (fill_reg == done) begin
                    wr_off_next = '0;
                    rd_off_next = '0;
                end else begin
                    rd_off_next = rd_adv;
                end
            end
            ACT_CLEAR: begin
                wr_off_next = '0;
                rd_off_next = '0;
                fill_next   = '0;
            end
            default: begin
                fill_next = fill_reg;
            end
        endcase
    end

    assign rd_chunk = SIZE - CNT_W'(rd_off_next);
    assign r_first  = (fill_next < rd_chunk) ? fill_next : rd_chunk;
    assign r_second = fill_next - r_first;
    assign free_new = SIZE - fill_next;
    assign wr_chunk = SIZE - CNT_W'(wr_off_next);
    assign w_first  = (free_new < wr_chunk) ? free_new : wr_chunk;
    assign w_second = free_new - w_first;

    assign done_w = 32'(done);
    assign fill_w = 32'(fill_next);
    assign rd_w   = 32'(rd_off_next);
    assign rf_w   = 32'(r_first);
    assign rs_w   = 32'(r_second);
    assign wr_w   = 32'(wr_off_next);
    assign wf_w   = 32'(w_first);
    assign ws_w   = 32'(w_second);

    always_comb begin
        result_next.done_count          = done_w[COUNT_W-1:0];
        result_next.fill_level          = fill_w[COUNT_W-1:0];
        result_next.read_start          = rd_w[OFFSET_W-1:0];
        result_next.read_first_length   = rf_w[COUNT_W-1:0];
        result_next.read_second_length  = rs_w[COUNT_W-1:0];
        result_next.write_start         = wr_w[OFFSET_W-1:0];
        result_next.write_first_length  = wf_w[COUNT_W-1:0];
        result_next.write_second_length = ws_w[COUNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wr_off_reg    <= '0;
            rd_off_reg    <= '0;
            fill_reg      <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                wr_off_reg    <= wr_off_next;
                rd_off_reg    <= rd_off_next;
                fill_reg      <= fill_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold payload until the next request moves
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            action_reg  <= s_tdata[ACTION_W-1:0];
            request_reg <= s_tdata[ACTION_W +: REQUEST_W];
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

endmodule
